[rtl/mcsh_pkg.sv]
// ----------------------------------------------------------------------------
// Masked colour split histogram: shared package
// Field widths, item kinds and fixed-point constants used by the interfaces
// and the histogram core.
// ----------------------------------------------------------------------------
package mcsh_pkg;

  localparam int KIND_W    = 2;
  localparam int COMP_W    = 8;
  localparam int BIN_IDX_W = 12;
  localparam int CFG_W     = 3;
  localparam int FRAC_BITS = 16;
  localparam int PROBA_W   = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(PROBA_W);

  localparam logic [CFG_W-1:0]   CFG_RESET = 3'd4;
  localparam logic [PROBA_W-1:0] PROBA_ONE = 17'h10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

endpackage

[rtl/mcsh_in_if.sv]
// ----------------------------------------------------------------------------
// Masked colour split histogram: input channel
// Pixel, read and clear items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcsh_in_if import mcsh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [COMP_W-1:0]    red;
  logic [COMP_W-1:0]    green;
  logic [COMP_W-1:0]    blue;
  logic                 in_mask;
  logic [BIN_IDX_W-1:0] bin_index;

  modport source (output valid, kind, red, green, blue, in_mask, bin_index, input ready);
  modport sink   (input valid, kind, red, green, blue, in_mask, bin_index, output ready);
endinterface

[rtl/mcsh_out_if.sv]
// ----------------------------------------------------------------------------
// Masked colour split histogram: result channel
// One bin's two counts and two Q16 probabilities per read item.
// ----------------------------------------------------------------------------
interface mcsh_out_if import mcsh_pkg::*; #(
  parameter int COUNT_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] inside_count;
  logic [COUNT_BITS-1:0] outside_count;
  logic [PROBA_W-1:0]    inside_proba;
  logic [PROBA_W-1:0]    outside_proba;

  modport source (output valid, inside_count, outside_count, inside_proba, outside_proba,
                  input ready);
  modport sink   (input valid, inside_count, outside_count, inside_proba, outside_proba,
                  output ready);
endinterface

[rtl/mcsh_cfg_if.sv]
// ----------------------------------------------------------------------------
// Masked colour split histogram: configuration channel
// Write channel for the bits-per-component register.
// ----------------------------------------------------------------------------
interface mcsh_cfg_if import mcsh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/masked_color_split_histogram.sv]
// ----------------------------------------------------------------------------
// Masked colour split histogram
// Counts RGB pixels into an inside or outside 3-D colour histogram held in
// one bin memory, and answers bin reads with counts and Q16 probabilities.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Carries
//  in_chan   in         valid/ready    kind, red, green, blue, in_mask, bin_index
//  out_chan  out        valid/ready    inside/outside count, inside/outside proba
//  cfg_chan  in         valid/ready    bits_per_component (ready always high)
//
//  Pixels are taken one per cycle while in_chan.ready is high; the bin memory is
//  read at acceptance and written back in the following cycle, with forwarding
//  for back-to-back hits. A read reaches its result through the memory read at
//  acceptance, the load state, the bit-serial divider and the output register.
//  Reset, a clear item and a configuration write start a clearing pass of
//  all 2^(3*MAX_COMPONENT_BITS) bins (4096 by default) with in_chan.ready low.
//  A held result on out_chan does not stop pixels; a second read waits for it.
//
module masked_color_split_histogram import mcsh_pkg::*; #(
  parameter int MAX_COMPONENT_BITS = 4,
  parameter int COUNT_BITS         = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  mcsh_in_if.sink    in_chan,
  mcsh_cfg_if.sink   cfg_chan,
  mcsh_out_if.source out_chan
);

  localparam int IDX_W  = 3 * MAX_COMPONENT_BITS;
  localparam int DEPTH  = 1 << IDX_W;
  localparam int WORD_W = 2 * COUNT_BITS;
  localparam int NUM_W  = COUNT_BITS + PROBA_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CFG_W-1:0]      BITS_MAX  = CFG_W'(MAX_COMPONENT_BITS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  state_t                state_r;
  logic [IDX_W-1:0]      clr_addr_r;
  logic [CFG_W-1:0]      bpc_r;
  logic [COUNT_BITS-1:0] in_total_r;
  logic [COUNT_BITS-1:0] out_total_r;

  logic                  s1_valid_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic                  s1_mask_r;
  logic                  fwd_hit_r;
  logic [WORD_W-1:0]     fwd_data_r;

  logic [WORD_W-1:0]     mem [DEPTH];
  logic [WORD_W-1:0]     mem_rdata_r;

  // Divider lanes: index 1 is inside, index 0 is outside.
  logic [COUNT_BITS-1:0] rem_r  [2];
  logic [PROBA_W-1:0]    nlo_r  [2];
  logic [PROBA_W-1:0]    quo_r  [2];
  logic [COUNT_BITS-1:0] tot_r  [2];
  logic [COUNT_BITS-1:0] cnt_r  [2];
  logic [STEP_W-1:0]     step_r;

  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] out_in_cnt_r;
  logic [COUNT_BITS-1:0] out_out_cnt_r;
  logic [PROBA_W-1:0]    out_in_p_r;
  logic [PROBA_W-1:0]    out_out_p_r;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  out_load;
  logic [CFG_W-1:0]      eff_bits;
  logic [3:0]            comp_sh;
  logic [COMP_W-1:0]     rq;
  logic [COMP_W-1:0]     gq;
  logic [COMP_W-1:0]     bq;
  logic [IDX_W-1:0]      pix_idx;
  logic [IDX_W-1:0]      mem_raddr;
  logic                  clearing;
  logic                  s1_we;
  logic [WORD_W-1:0]     s1_old;
  logic [WORD_W-1:0]     s1_wdata;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;

  logic [COUNT_BITS-1:0] ld_cnt  [2];
  logic [COUNT_BITS-1:0] ld_tot  [2];
  logic [NUM_W-1:0]      ld_num  [2];
  logic [COUNT_BITS:0]   st_rem2 [2];
  logic                  st_ge   [2];
  logic [COUNT_BITS-1:0] st_rem  [2];
  logic [PROBA_W-1:0]    res_p   [2];

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign cfg_acc  = cfg_chan.valid && cfg_chan.ready;
  assign clearing = (state_r == ST_CLEAR);

  // A configuration write takes the cycle; no input transaction is taken beside it.
  assign in_chan.ready  = (state_r == ST_RUN) && !cfg_chan.valid;
  assign cfg_chan.ready = 1'b1;

  assign out_load = (state_r == ST_DONE) && !cfg_acc && (!out_valid_r || out_chan.ready);

  // Bin of a pixel: the top eff_bits bits of each component, red uppermost.
  assign eff_bits = (bpc_r > BITS_MAX) ? BITS_MAX : bpc_r;
  assign comp_sh  = 4'(COMP_W) - {1'b0, eff_bits};
  assign rq       = in_chan.red   >> comp_sh;
  assign gq       = in_chan.green >> comp_sh;
  assign bq       = in_chan.blue  >> comp_sh;
  assign pix_idx  = (IDX_W'(rq) << {eff_bits, 1'b0}) | (IDX_W'(gq) << eff_bits) | IDX_W'(bq);

  assign mem_raddr = (in_chan.kind == KIND_READ) ? IDX_W'(in_chan.bin_index) : pix_idx;

  // Read-modify-write of the pixel in the cycle after acceptance.
  assign s1_we  = s1_valid_r && !clearing;
  assign s1_old = fwd_hit_r ? fwd_data_r : mem_rdata_r;

  always_comb begin
    s1_wdata = s1_old;
    if (s1_mask_r) begin
      s1_wdata[WORD_W-1:COUNT_BITS] = sat_inc(s1_old[WORD_W-1:COUNT_BITS]);
    end else begin
      s1_wdata[COUNT_BITS-1:0] = sat_inc(s1_old[COUNT_BITS-1:0]);
    end
  end

  assign mem_we    = clearing || s1_we;
  assign mem_waddr = clearing ? clr_addr_r : s1_idx_r;
  assign mem_wdata = clearing ? '0 : s1_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // Divider load values and one restoring step per lane.
  always_comb begin
    ld_cnt[1] = s1_old[WORD_W-1:COUNT_BITS];
    ld_cnt[0] = s1_old[COUNT_BITS-1:0];
    ld_tot[1] = in_total_r;
    ld_tot[0] = out_total_r;
    for (int j = 0; j < 2; j++) begin
      ld_num[j]  = NUM_W'({ld_cnt[j], FRAC_BITS'(0)}) + NUM_W'(ld_tot[j] >> 1);
      st_rem2[j] = {rem_r[j], nlo_r[j][PROBA_W-1]};
      st_ge[j]   = (st_rem2[j] >= {1'b0, tot_r[j]});
      st_rem[j]  = st_ge[j] ? COUNT_BITS'(st_rem2[j] - {1'b0, tot_r[j]})
                            : COUNT_BITS'(st_rem2[j]);
      res_p[j]   = (tot_r[j] == '0) ? '0 : quo_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      bpc_r       <= CFG_RESET;
      in_total_r  <= '0;
      out_total_r <= '0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      s1_valid_r <= in_acc && (in_chan.kind == KIND_PIXEL);
      s1_idx_r   <= mem_raddr;
      s1_mask_r  <= in_chan.in_mask;
      fwd_hit_r  <= s1_we && (s1_idx_r == mem_raddr);
      fwd_data_r <= s1_wdata;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.valid && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_acc) begin
        // A new bin layout invalidates every count.
        bpc_r       <= cfg_chan.data;
        state_r     <= ST_CLEAR;
        clr_addr_r  <= '0;
        in_total_r  <= '0;
        out_total_r <= '0;
      end else begin
        case (state_r)
          ST_CLEAR: begin
            clr_addr_r <= clr_addr_r + 1'b1;
            if (clr_addr_r == '1) begin
              state_r <= ST_RUN;
            end
          end
          ST_RUN: begin
            if (in_acc) begin
              case (in_chan.kind)
                KIND_PIXEL: begin
                  if (in_chan.in_mask) begin
                    in_total_r <= sat_inc(in_total_r);
                  end else begin
                    out_total_r <= sat_inc(out_total_r);
                  end
                end
                KIND_READ: begin
                  state_r <= ST_LOAD;
                end
                KIND_CLEAR: begin
                  state_r     <= ST_CLEAR;
                  clr_addr_r  <= '0;
                  in_total_r  <= '0;
                  out_total_r <= '0;
                end
                default: ;
              endcase
            end
          end
          ST_LOAD: begin
            for (int j = 0; j < 2; j++) begin
              rem_r[j] <= ld_num[j][NUM_W-1:PROBA_W];
              nlo_r[j] <= ld_num[j][PROBA_W-1:0];
              quo_r[j] <= '0;
              tot_r[j] <= ld_tot[j];
              cnt_r[j] <= ld_cnt[j];
            end
            step_r  <= '0;
            state_r <= ST_DIV;
          end
          ST_DIV: begin
            for (int j = 0; j < 2; j++) begin
              rem_r[j] <= st_rem[j];
              nlo_r[j] <= {nlo_r[j][PROBA_W-2:0], 1'b0};
              quo_r[j] <= {quo_r[j][PROBA_W-2:0], st_ge[j]};
            end
            step_r <= step_r + 1'b1;
            if (step_r == STEP_W'(PROBA_W - 1)) begin
              state_r <= ST_DONE;
            end
          end
          ST_DONE: begin
            if (out_load) begin
              out_in_cnt_r  <= cnt_r[1];
              out_out_cnt_r <= cnt_r[0];
              out_in_p_r    <= res_p[1];
              out_out_p_r   <= res_p[0];
              state_r       <= ST_RUN;
            end
          end
          default: state_r <= ST_CLEAR;
        endcase
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.inside_count  = out_in_cnt_r;
  assign out_chan.outside_count = out_out_cnt_r;
  assign out_chan.inside_proba  = out_in_p_r;
  assign out_chan.outside_proba = out_out_p_r;

  // A bin never exceeds its total, so no probability can pass one.
  a_proba_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.inside_proba <= PROBA_ONE) &&
                       (out_chan.outside_proba <= PROBA_ONE))
    else $error("probability above one on the result channel");

  a_read_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.kind == KIND_READ && !cfg_acc) |=> (state_r == ST_LOAD))
    else $error("accepted read did not move to the divider load");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> $past(s1_we))
    else $error("forwarding hit without a write-back in the previous cycle");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.kind == KIND_CLEAR && !cfg_acc) |=>
      (in_total_r == '0) && (out_total_r == '0) && clearing)
    else $error("clear item did not reset the totals and start a sweep");

endmodule
